// ===== rtl/qewa_pkg.sv =====
// Shared types, constants and helpers for the quaternion Euler-angle and
// world-acceleration pipeline. No dependencies.
package qewa_pkg;

    // datapath widths
    localparam int QW        = 16;   // input and output field width
    localparam int VW        = 34;   // sums of 16x16 products, times two
    localparam int CW        = 38;   // CORDIC x/y with gain and pre-rotation headroom
    localparam int AW        = 34;   // angles, Q30 radians
    localparam int PW        = 50;   // 16 x 34 products
    localparam int WW        = 54;   // world accumulators, Q36
    localparam int DW        = 57;   // angle times degrees-per-radian
    localparam int ISQRT_LAT = 16;   // square root stages, two digits each

    // configuration register indexes
    localparam int               CFG_IDX_W      = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_UNIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY    = 2'd1;

    // pitch handling codes
    localparam logic [1:0] PM_CORDIC   = 2'd0;
    localparam logic [1:0] PM_ZERO     = 2'd1;
    localparam logic [1:0] PM_POS_HALF = 2'd2;
    localparam logic [1:0] PM_NEG_HALF = 2'd3;

    localparam logic signed [AW-1:0] HALF_PI_Q30     = 34'sd1686629713;
    localparam logic [21:0]          DEG_PER_RAD_Q16 = 22'd3754936;

    // atan(2^-s) in Q30 radians
    localparam logic [29:0] ATAN_TAB [24] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
        30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
        30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

    // item side data waiting for the square root
    typedef struct packed {
        logic signed [VW-1:0] yaw_y;
        logic signed [VW-1:0] yaw_x;
        logic signed [VW-1:0] roll_y;
        logic signed [VW-1:0] roll_x;
        logic                 pitch_neg;
        logic [31:0]          pitch_h;
        logic [1:0]           pitch_mode;
        logic                 sat;
        logic signed [QW-1:0] wx;
        logic signed [QW-1:0] wy;
        logic signed [QW-1:0] wz;
    } side_t;

    // item side data waiting for the CORDIC units
    typedef struct packed {
        logic [1:0]           pitch_mode;
        logic                 sat;
        logic signed [QW-1:0] wx;
        logic signed [QW-1:0] wy;
        logic signed [QW-1:0] wz;
    } post_t;

    // sign extension of a 32-bit product to sum width
    function automatic logic signed [VW-1:0] sx34(input logic signed [31:0] v);
        return {{(VW-32){v[31]}}, v};
    endfunction

    // clamp to 16 bits; returns {clamped, value}
    function automatic logic [QW:0] sat16(input logic signed [63:0] v);
        logic [QW:0] res;
        if (v > 64'sd32767) begin
            res = {1'b1, 16'h7FFF};
        end else if (v < -64'sd32768) begin
            res = {1'b1, 16'h8000};
        end else begin
            res = {1'b0, v[QW-1:0]};
        end
        return res;
    endfunction

endpackage

// ===== rtl/qewa_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) in Q30 radians, one stage per step.
// Depends on qewa_pkg.
module qewa_cordic #(
    parameter int STEPS = 16
) (
    input  logic                            aclk,
    input  logic                            en,
    input  logic signed [qewa_pkg::CW-1:0]  x_in,
    input  logic signed [qewa_pkg::CW-1:0]  y_in,
    output logic signed [qewa_pkg::AW-1:0]  ang_out
);
    localparam int CW = qewa_pkg::CW;
    localparam int AW = qewa_pkg::AW;

    logic signed [CW-1:0] x_reg   [STEPS+1];
    logic signed [CW-1:0] y_reg   [STEPS+1];
    logic signed [AW-1:0] ang_reg [STEPS+1];
    logic                 zero_reg[STEPS+1];

    // quadrant pre-rotation, then one micro-rotation per stage
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in[CW-1]) begin
                if (!y_in[CW-1]) begin
                    ang_reg[0] <= qewa_pkg::HALF_PI_Q30;
                    x_reg[0]   <= y_in;
                    y_reg[0]   <= -x_in;
                end else begin
                    ang_reg[0] <= -qewa_pkg::HALF_PI_Q30;
                    x_reg[0]   <= -y_in;
                    y_reg[0]   <= x_in;
                end
            end else begin
                ang_reg[0] <= '0;
                x_reg[0]   <= x_in;
                y_reg[0]   <= y_in;
            end
            for (int s = 0; s < STEPS; s++) begin
                zero_reg[s+1] <= zero_reg[s];
                if (!y_reg[s][CW-1]) begin
                    x_reg[s+1]   <= x_reg[s] + (y_reg[s] >>> s);
                    y_reg[s+1]   <= y_reg[s] - (x_reg[s] >>> s);
                    ang_reg[s+1] <= ang_reg[s]
                                  + $signed({{(AW-30){1'b0}}, qewa_pkg::ATAN_TAB[s]});
                end else begin
                    x_reg[s+1]   <= x_reg[s] - (y_reg[s] >>> s);
                    y_reg[s+1]   <= y_reg[s] + (x_reg[s] >>> s);
                    ang_reg[s+1] <= ang_reg[s]
                                  - $signed({{(AW-30){1'b0}}, qewa_pkg::ATAN_TAB[s]});
                end
            end
        end
    end

    // zero vector gives angle zero
    assign ang_out = zero_reg[STEPS] ? '0 : ang_reg[STEPS];

endmodule

// ===== rtl/qewa_isqrt.sv =====
// Pipelined 64-bit integer square root, two result bits per stage.
// Depends on qewa_pkg.
module qewa_isqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] v_in,
    output logic [31:0] root_out
);
    localparam int STAGES = qewa_pkg::ISQRT_LAT;

    logic [63:0] v_reg[STAGES];
    logic [63:0] r_reg[STAGES];

    // one digit: try subtracting res + bit
    function automatic logic [127:0] root_step(input logic [63:0] v,
                                               input logic [63:0] res,
                                               input logic [63:0] bitv);
        logic [63:0] trial;
        trial = res + bitv;
        if (v >= trial) begin
            return {v - trial, (res >> 1) + bitv};
        end
        return {v, res >> 1};
    endfunction

    always_ff @(posedge aclk) begin
        logic [127:0] t0;
        logic [127:0] t1;
        if (en) begin
            for (int g = 0; g < STAGES; g++) begin
                if (g == 0) begin
                    t0 = root_step(v_in, 64'd0, 64'd1 << (62 - 4*g));
                end else begin
                    t0 = root_step(v_reg[g-1], r_reg[g-1], 64'd1 << (62 - 4*g));
                end
                t1 = root_step(t0[127:64], t0[63:0], 64'd1 << (60 - 4*g));
                v_reg[g] <= t1[127:64];
                r_reg[g] <= t1[63:0];
            end
        end
    end

    assign root_out = r_reg[STAGES-1][31:0];

endmodule

// ===== rtl/quaternion_euler_and_world_accel.sv =====
// Top level: quaternion to yaw/pitch/roll and world-frame acceleration.
// Depends on qewa_pkg, qewa_cordic and qewa_isqrt.
//
// Usage:
//   s_ channel: one transfer carries a Q14 quaternion and a Q8 body-frame
//   acceleration sample. m_ channel: one transfer per input carries yaw,
//   pitch, roll (Q7 degrees or Q13 radians) and the world acceleration with
//   gravity taken off z; m_tuser flags any clamping.
//   cfg_ channel: index 0 selects the angle unit, index 1 sets gravity
//   (Q8). Always ready; write only while the pipeline is empty.
// Pipeline: CORDIC_STEPS + 24 register stages from input transfer to m_tvalid:
//   input register, four multiply/sum stages, sixteen square-root stages,
//   CORDIC_STEPS + 1 CORDIC stages, two angle scaling stages.
// Throughput: one item per cycle while the output is not stalled; every stage is a register.
// Reset clears all valid bits and loads angle unit = degrees, gravity = 2510.
// When m_tready is low with a result held, the whole pipeline freezes and
//   s_tready drops; nothing is lost or repeated. Bubbles keep filling while
//   the output register is empty.
module quaternion_euler_and_world_accel #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // quat_real, quat_i, quat_j, quat_k, accel_x, accel_y, accel_z
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // yaw_angle, pitch_angle, roll_angle, world_accel_x, world_accel_y, world_accel_z
    output logic [95:0]  m_tdata,
    // saturated
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [qewa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [11:0]  cfg_data
);
    localparam int QW   = qewa_pkg::QW;
    localparam int VW   = qewa_pkg::VW;
    localparam int CW   = qewa_pkg::CW;
    localparam int AW   = qewa_pkg::AW;
    localparam int PW   = qewa_pkg::PW;
    localparam int WW   = qewa_pkg::WW;
    localparam int DW   = qewa_pkg::DW;
    localparam int SQL  = qewa_pkg::ISQRT_LAT;
    localparam int CRL  = CORDIC_STEPS + 1;
    localparam int NST  = 5 + SQL + CRL + 2;

    localparam logic signed [WW-1:0] W_HALF = 54'sd134217728;      // 2^27
    localparam logic signed [DW-1:0] D_HALF = 57'sd274877906944;   // 2^38
    localparam logic signed [AW-1:0] R_HALF = 34'sd65536;          // 2^16

    logic en;
    logic [NST-1:0] vld_reg;

    // configuration registers
    logic        deg_reg;
    logic [11:0] grav_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deg_reg  <= 1'b1;
            grav_reg <= 12'd2510;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                qewa_pkg::CFG_ANGLE_UNIT: deg_reg  <= cfg_data[0];
                qewa_pkg::CFG_GRAVITY:    grav_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: output empty or being taken
    assign en       = !vld_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // stage A: input register
    logic signed [QW-1:0] a_qr_reg, a_qi_reg, a_qj_reg, a_qk_reg;
    logic signed [QW-1:0] a_ax_reg, a_ay_reg, a_az_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_qr_reg <= s_tdata[15:0];
            a_qi_reg <= s_tdata[31:16];
            a_qj_reg <= s_tdata[47:32];
            a_qk_reg <= s_tdata[63:48];
            a_ax_reg <= s_tdata[79:64];
            a_ay_reg <= s_tdata[95:80];
            a_az_reg <= s_tdata[111:96];
        end
    end

    // stage B: all 16x16 products
    logic signed [31:0] b_sr_reg, b_si_reg, b_sj_reg, b_sk_reg;
    logic signed [31:0] b_ij_reg, b_kr_reg, b_jk_reg, b_ir_reg, b_jr_reg, b_ik_reg;
    logic signed [31:0] b_jz_reg, b_ky_reg, b_kx_reg, b_iz_reg, b_iy_reg, b_jx_reg;
    logic signed [QW-1:0] b_qr_reg, b_qi_reg, b_qj_reg, b_qk_reg;
    logic signed [QW-1:0] b_ax_reg, b_ay_reg, b_az_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            b_sr_reg <= a_qr_reg * a_qr_reg;
            b_si_reg <= a_qi_reg * a_qi_reg;
            b_sj_reg <= a_qj_reg * a_qj_reg;
            b_sk_reg <= a_qk_reg * a_qk_reg;
            b_ij_reg <= a_qi_reg * a_qj_reg;
            b_kr_reg <= a_qk_reg * a_qr_reg;
            b_jk_reg <= a_qj_reg * a_qk_reg;
            b_ir_reg <= a_qi_reg * a_qr_reg;
            b_jr_reg <= a_qj_reg * a_qr_reg;
            b_ik_reg <= a_qi_reg * a_qk_reg;
            b_jz_reg <= a_qj_reg * a_az_reg;
            b_ky_reg <= a_qk_reg * a_ay_reg;
            b_kx_reg <= a_qk_reg * a_ax_reg;
            b_iz_reg <= a_qi_reg * a_az_reg;
            b_iy_reg <= a_qi_reg * a_ay_reg;
            b_jx_reg <= a_qj_reg * a_ax_reg;
            b_qr_reg <= a_qr_reg;
            b_qi_reg <= a_qi_reg;
            b_qj_reg <= a_qj_reg;
            b_qk_reg <= a_qk_reg;
            b_ax_reg <= a_ax_reg;
            b_ay_reg <= a_ay_reg;
            b_az_reg <= a_az_reg;
        end
    end

    // stage C: atan2 operands, norm, asin numerator, t = 2(q x v)
    logic signed [VW-1:0] c_yaw_y_reg, c_yaw_x_reg, c_roll_y_reg, c_roll_x_reg;
    logic signed [VW-1:0] c_d_reg, c_n_reg, c_tx_reg, c_ty_reg, c_tz_reg;
    logic signed [QW-1:0] c_qr_reg, c_qi_reg, c_qj_reg, c_qk_reg;
    logic signed [QW-1:0] c_ax_reg, c_ay_reg, c_az_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c_yaw_y_reg  <= (qewa_pkg::sx34(b_ij_reg) + qewa_pkg::sx34(b_kr_reg)) <<< 1;
            c_yaw_x_reg  <= qewa_pkg::sx34(b_si_reg) - qewa_pkg::sx34(b_sj_reg)
                          - qewa_pkg::sx34(b_sk_reg) + qewa_pkg::sx34(b_sr_reg);
            c_roll_y_reg <= (qewa_pkg::sx34(b_jk_reg) + qewa_pkg::sx34(b_ir_reg)) <<< 1;
            c_roll_x_reg <= qewa_pkg::sx34(b_sk_reg) + qewa_pkg::sx34(b_sr_reg)
                          - qewa_pkg::sx34(b_si_reg) - qewa_pkg::sx34(b_sj_reg);
            c_d_reg      <= qewa_pkg::sx34(b_sr_reg) + qewa_pkg::sx34(b_si_reg)
                          + qewa_pkg::sx34(b_sj_reg) + qewa_pkg::sx34(b_sk_reg);
            c_n_reg      <= (qewa_pkg::sx34(b_jr_reg) - qewa_pkg::sx34(b_ik_reg)) <<< 1;
            c_tx_reg     <= (qewa_pkg::sx34(b_jz_reg) - qewa_pkg::sx34(b_ky_reg)) <<< 1;
            c_ty_reg     <= (qewa_pkg::sx34(b_kx_reg) - qewa_pkg::sx34(b_iz_reg)) <<< 1;
            c_tz_reg     <= (qewa_pkg::sx34(b_iy_reg) - qewa_pkg::sx34(b_jx_reg)) <<< 1;
            c_qr_reg <= b_qr_reg;
            c_qi_reg <= b_qi_reg;
            c_qj_reg <= b_qj_reg;
            c_qk_reg <= b_qk_reg;
            c_ax_reg <= b_ax_reg;
            c_ay_reg <= b_ay_reg;
            c_az_reg <= b_az_reg;
        end
    end

    // stage D: pitch classification and half terms, rotation products
    logic signed [VW-1:0] c_an;
    logic [1:0]           c_mode;

    always_comb begin
        c_an = c_n_reg[VW-1] ? -c_n_reg : c_n_reg;
        if (c_d_reg == '0) begin
            c_mode = qewa_pkg::PM_ZERO;
        end else if (c_an >= c_d_reg) begin
            c_mode = c_n_reg[VW-1] ? qewa_pkg::PM_NEG_HALF : qewa_pkg::PM_POS_HALF;
        end else begin
            c_mode = qewa_pkg::PM_CORDIC;
        end
    end

    logic signed [VW-1:0] d_yaw_y_reg, d_yaw_x_reg, d_roll_y_reg, d_roll_x_reg;
    logic                 d_neg_reg, d_clamp_reg;
    logic [1:0]           d_mode_reg;
    logic [31:0]          d_h_reg, d_dm_reg, d_dp_reg;
    logic signed [PW-1:0] d_rtx_reg, d_jtz_reg, d_kty_reg;
    logic signed [PW-1:0] d_rty_reg, d_ktx_reg, d_itz_reg;
    logic signed [PW-1:0] d_rtz_reg, d_ity_reg, d_jtx_reg;
    logic signed [QW-1:0] d_ax_reg, d_ay_reg, d_az_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_yaw_y_reg  <= c_yaw_y_reg;
            d_yaw_x_reg  <= c_yaw_x_reg;
            d_roll_y_reg <= c_roll_y_reg;
            d_roll_x_reg <= c_roll_x_reg;
            d_neg_reg    <= c_n_reg[VW-1];
            d_mode_reg   <= c_mode;
            d_clamp_reg  <= (c_d_reg != '0) && (c_an > c_d_reg);
            d_h_reg      <= c_an[32:1];
            d_dm_reg     <= c_d_reg[32:1] - c_an[32:1];
            d_dp_reg     <= c_d_reg[32:1] + c_an[32:1];
            d_rtx_reg    <= c_qr_reg * c_tx_reg;
            d_jtz_reg    <= c_qj_reg * c_tz_reg;
            d_kty_reg    <= c_qk_reg * c_ty_reg;
            d_rty_reg    <= c_qr_reg * c_ty_reg;
            d_ktx_reg    <= c_qk_reg * c_tx_reg;
            d_itz_reg    <= c_qi_reg * c_tz_reg;
            d_rtz_reg    <= c_qr_reg * c_tz_reg;
            d_ity_reg    <= c_qi_reg * c_ty_reg;
            d_jtx_reg    <= c_qj_reg * c_tx_reg;
            d_ax_reg     <= c_ax_reg;
            d_ay_reg     <= c_ay_reg;
            d_az_reg     <= c_az_reg;
        end
    end

    // stage E: square root operand, world accumulators in Q36
    logic [63:0]          e_prod_reg;
    logic signed [WW-1:0] e_wx_reg, e_wy_reg, e_wz_reg;
    logic signed [VW-1:0] e_yaw_y_reg, e_yaw_x_reg, e_roll_y_reg, e_roll_x_reg;
    logic                 e_neg_reg, e_clamp_reg;
    logic [1:0]           e_mode_reg;
    logic [31:0]          e_h_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            e_prod_reg   <= d_dm_reg * d_dp_reg;
            e_wx_reg     <= (WW'(d_ax_reg) <<< 28) + d_rtx_reg + d_jtz_reg - d_kty_reg;
            e_wy_reg     <= (WW'(d_ay_reg) <<< 28) + d_rty_reg + d_ktx_reg - d_itz_reg;
            e_wz_reg     <= (WW'(d_az_reg) <<< 28) + d_rtz_reg + d_ity_reg - d_jtx_reg
                          - (WW'($signed({1'b0, grav_reg})) <<< 28);
            e_yaw_y_reg  <= d_yaw_y_reg;
            e_yaw_x_reg  <= d_yaw_x_reg;
            e_roll_y_reg <= d_roll_y_reg;
            e_roll_x_reg <= d_roll_x_reg;
            e_neg_reg    <= d_neg_reg;
            e_clamp_reg  <= d_clamp_reg;
            e_mode_reg   <= d_mode_reg;
            e_h_reg      <= d_h_reg;
        end
    end

    // round and clamp world components
    logic [QW:0]     e_satx, e_saty, e_satz;
    qewa_pkg::side_t e_side;

    always_comb begin
        e_satx = qewa_pkg::sat16(64'((e_wx_reg + W_HALF) >>> 28));
        e_saty = qewa_pkg::sat16(64'((e_wy_reg + W_HALF) >>> 28));
        e_satz = qewa_pkg::sat16(64'((e_wz_reg + W_HALF) >>> 28));
        e_side.yaw_y      = e_yaw_y_reg;
        e_side.yaw_x      = e_yaw_x_reg;
        e_side.roll_y     = e_roll_y_reg;
        e_side.roll_x     = e_roll_x_reg;
        e_side.pitch_neg  = e_neg_reg;
        e_side.pitch_h    = e_h_reg;
        e_side.pitch_mode = e_mode_reg;
        e_side.sat        = e_clamp_reg | e_satx[QW] | e_saty[QW] | e_satz[QW];
        e_side.wx         = e_satx[QW-1:0];
        e_side.wy         = e_saty[QW-1:0];
        e_side.wz         = e_satz[QW-1:0];
    end

    // square root of (D-h)(D+h), side data alongside
    logic [31:0] sq_root;

    qewa_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .v_in     (e_prod_reg),
        .root_out (sq_root)
    );

    qewa_pkg::side_t line1_reg[SQL];

    always_ff @(posedge aclk) begin
        if (en) begin
            line1_reg[0] <= e_side;
            for (int s = 1; s < SQL; s++) begin
                line1_reg[s] <= line1_reg[s-1];
            end
        end
    end

    // three CORDIC units start together
    qewa_pkg::side_t      s1;
    logic signed [CW-1:0] p_x, p_y, p_h;
    logic signed [AW-1:0] yaw_ang, pitch_ang, roll_ang;
    qewa_pkg::post_t      s1_post;

    always_comb begin
        s1  = line1_reg[SQL-1];
        p_x = $signed({{(CW-32){1'b0}}, sq_root});
        p_h = $signed({{(CW-32){1'b0}}, s1.pitch_h});
        p_y = s1.pitch_neg ? -p_h : p_h;
        s1_post.pitch_mode = s1.pitch_mode;
        s1_post.sat        = s1.sat;
        s1_post.wx         = s1.wx;
        s1_post.wy         = s1.wy;
        s1_post.wz         = s1.wz;
    end

    qewa_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
        .aclk    (aclk),
        .en      (en),
        .x_in    (CW'($signed(s1.yaw_x))),
        .y_in    (CW'($signed(s1.yaw_y))),
        .ang_out (yaw_ang)
    );

    qewa_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .aclk    (aclk),
        .en      (en),
        .x_in    (p_x),
        .y_in    (p_y),
        .ang_out (pitch_ang)
    );

    qewa_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
        .aclk    (aclk),
        .en      (en),
        .x_in    (CW'($signed(s1.roll_x))),
        .y_in    (CW'($signed(s1.roll_y))),
        .ang_out (roll_ang)
    );

    qewa_pkg::post_t line2_reg[CRL];

    always_ff @(posedge aclk) begin
        if (en) begin
            line2_reg[0] <= s1_post;
            for (int s = 1; s < CRL; s++) begin
                line2_reg[s] <= line2_reg[s-1];
            end
        end
    end

    // stage G: pitch special cases, degree products
    qewa_pkg::post_t      s2;
    logic signed [AW-1:0] pitch_sel;
    logic signed [22:0]   deg_k;

    always_comb begin
        s2    = line2_reg[CRL-1];
        deg_k = $signed({1'b0, qewa_pkg::DEG_PER_RAD_Q16});
        case (s2.pitch_mode)
            qewa_pkg::PM_ZERO:     pitch_sel = '0;
            qewa_pkg::PM_POS_HALF: pitch_sel = qewa_pkg::HALF_PI_Q30;
            qewa_pkg::PM_NEG_HALF: pitch_sel = -qewa_pkg::HALF_PI_Q30;
            default:               pitch_sel = pitch_ang;
        endcase
    end

    logic signed [AW-1:0] g_yaw_reg, g_pitch_reg, g_roll_reg;
    logic signed [DW-1:0] g_yaw_deg_reg, g_pitch_deg_reg, g_roll_deg_reg;
    qewa_pkg::post_t      g_post_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            g_yaw_reg       <= yaw_ang;
            g_pitch_reg     <= pitch_sel;
            g_roll_reg      <= roll_ang;
            g_yaw_deg_reg   <= yaw_ang * deg_k;
            g_pitch_deg_reg <= pitch_sel * deg_k;
            g_roll_deg_reg  <= roll_ang * deg_k;
            g_post_reg      <= s2;
        end
    end

    // stage H: unit scaling and clamp into the output register
    logic [QW:0] h_yaw, h_pitch, h_roll;

    always_comb begin
        if (deg_reg) begin
            h_yaw   = qewa_pkg::sat16(64'((g_yaw_deg_reg + D_HALF) >>> 39));
            h_pitch = qewa_pkg::sat16(64'((g_pitch_deg_reg + D_HALF) >>> 39));
            h_roll  = qewa_pkg::sat16(64'((g_roll_deg_reg + D_HALF) >>> 39));
        end else begin
            h_yaw   = qewa_pkg::sat16(64'((g_yaw_reg + R_HALF) >>> 17));
            h_pitch = qewa_pkg::sat16(64'((g_pitch_reg + R_HALF) >>> 17));
            h_roll  = qewa_pkg::sat16(64'((g_roll_reg + R_HALF) >>> 17));
        end
    end

    logic [95:0] m_data_reg;
    logic        m_sat_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {g_post_reg.wz, g_post_reg.wy, g_post_reg.wx,
                           h_roll[QW-1:0], h_pitch[QW-1:0], h_yaw[QW-1:0]};
            m_sat_reg  <= g_post_reg.sat | h_yaw[QW] | h_pitch[QW] | h_roll[QW];
        end
    end

    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_sat_reg;

endmodule

// ===== rtl/qewa_checker.sv =====
// Port-level checks for the quaternion Euler-angle pipeline, bound to the top.
// Depends on quaternion_euler_and_world_accel.
module qewa_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata,
    input logic [0:0]   m_tuser
);

    // a held result keeps its payload until transferred
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input side advances exactly when the output register can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

endmodule

bind quaternion_euler_and_world_accel qewa_checker u_qewa_checker (.*);
